// ===== hdl/gs_pkg.sv =====
// Shared types and constants for the adjacency-matrix graph store.
// Depends on nothing; used by gs_seq and adjacency_matrix_graph_store.
package gs_pkg;

	// default node capacity
	localparam int GS_MAX_NODES = 64;

	// item opcodes; codes above OP_QUERY_EDGE are unknown and change nothing
	typedef enum logic [2:0] {
		OP_ADD_NODE  = 3'd0,
		OP_DEL_NODE  = 3'd1,
		OP_ADD_EDGE  = 3'd2,
		OP_DEL_EDGE  = 3'd3,
		OP_QUERY_EDGE = 3'd4
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_ABSENT   = 2'd2,
		ST_NOCHANGE = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_EDGE,
		S_DEL_LOAD,
		S_WALK
	} state_t;

	// datapath action for the current cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CAPTURE,
		ACT_ADD,
		ACT_FULL,
		ACT_ABSENT,
		ACT_UNKNOWN,
		ACT_EDGE_RD,
		ACT_EDGE_EX,
		ACT_DEL_RD,
		ACT_DEL_LOAD,
		ACT_WALK
	} act_t;

	// sequencer to datapath
	typedef struct packed {
		act_t act;
		logic busy;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       a_ok;
		logic       b_ok;
		logic       walk_last;
	} stat_t;

endpackage

// ===== hdl/gs_row_ram.sv =====
// Adjacency row memory: one write port, one read port with registered data.
// Depends on nothing.
module gs_row_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/gs_seq.sv =====
// Sequencer for the graph store: steps one item through check, row access and
// the delete walk. Depends on gs_pkg.
module gs_seq import gs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				unique case (stat.op)
					OP_DEL_NODE: state_d = stat.a_ok ? S_DEL_LOAD : S_IDLE;
					OP_ADD_EDGE, OP_DEL_EDGE, OP_QUERY_EDGE: begin
						state_d = (stat.a_ok && stat.b_ok) ? S_EDGE : S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EDGE:     state_d = S_IDLE;
			S_DEL_LOAD: state_d = S_WALK;
			S_WALK: begin
				if (stat.walk_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl.busy = 1'b1;
		ctrl.act  = ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				ctrl.busy = 1'b0;
				ctrl.act  = start ? ACT_CAPTURE : ACT_NONE;
			end
			S_CHECK: begin
				unique case (stat.op)
					OP_ADD_NODE: ctrl.act = stat.full ? ACT_FULL : ACT_ADD;
					OP_DEL_NODE: ctrl.act = stat.a_ok ? ACT_DEL_RD : ACT_ABSENT;
					OP_ADD_EDGE, OP_DEL_EDGE, OP_QUERY_EDGE: begin
						ctrl.act = (stat.a_ok && stat.b_ok) ? ACT_EDGE_RD : ACT_ABSENT;
					end
					default: ctrl.act = ACT_UNKNOWN;
				endcase
			end
			S_EDGE:     ctrl.act = ACT_EDGE_EX;
			S_DEL_LOAD: ctrl.act = ACT_DEL_LOAD;
			S_WALK:     ctrl.act = ACT_WALK;
			default:    ctrl.act = ACT_NONE;
		endcase
	end

endmodule

// ===== hdl/adjacency_matrix_graph_store.sv =====
// Add-node, failures and unknown codes resolve in the check state; edge ops and
// queries read row a there and act on it in the edge state; delete-node then loads
// row a and walks all nodes_used rows, one adjacency row per cycle. busy is low in
// the cycle done is shown; no new item is taken while one is in progress.
// Asynchronous reset clears live marks, counts and control; a node's row is
// zeroed when it is added, so the row memory needs no clearing pass.
module adjacency_matrix_graph_store import gs_pkg::*; #(
	parameter int MAX_NODES = GS_MAX_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [5:0]  node_a,
	input  logic [5:0]  node_b,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  new_node,
	output logic        edge_present,
	output logic [12:0] edge_count,
	output logic [6:0]  nodes_used
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NXW = $clog2(MAX_NODES + 1);
	localparam int CW  = $clog2(MAX_NODES * MAX_NODES + 1);
	localparam int IW  = (NXW > 6) ? NXW : 6;
	localparam logic [MAX_NODES-1:0] BIT0 = MAX_NODES'(1);

	ctrl_t ctrl;
	stat_t stat;

	// control state
	logic [MAX_NODES-1:0] live_q;
	logic [NXW-1:0]       next_q;
	logic [CW-1:0]        count_q;
	logic                 done_q;

	// captured item and walk state
	logic [2:0]           op_q;
	logic [5:0]           a_q, b_q;
	logic [MAX_NODES-1:0] row_q;
	logic [NW-1:0]        j_q;

	// result registers
	status_t   status_q;
	logic [5:0] new_node_q;
	logic       present_q;
	logic [12:0] count_out_q;
	logic [6:0] used_q;

	// memory ports
	logic                 ram_we, ram_re;
	logic [NW-1:0]        ram_waddr, ram_raddr;
	logic [MAX_NODES-1:0] ram_wdata, ram_rdata;

	// index decode
	logic [IW-1:0] a_wide, b_wide;
	logic [NW-1:0] a_idx, b_idx, fresh_idx;
	logic          edge_bit, walk_last, j_is_a;
	logic [MAX_NODES-1:0] a_mask, b_mask;

	// shared count unit
	logic          cnt_sub;
	logic [1:0]    cnt_amt;
	logic [CW-1:0] cnt_next;

	// result selection
	logic    res_load;
	status_t res_status;
	logic    res_present;
	logic [5:0] res_new;

	assign a_wide    = IW'(a_q);
	assign b_wide    = IW'(b_q);
	assign a_idx     = a_wide[NW-1:0];
	assign b_idx     = b_wide[NW-1:0];
	assign fresh_idx = next_q[NW-1:0];
	assign a_mask    = BIT0 << a_idx;
	assign b_mask    = BIT0 << b_idx;
	assign edge_bit  = ram_rdata[b_idx];
	assign j_is_a    = (j_q == a_idx);
	assign walk_last = ((NXW'(j_q) + NXW'(1)) == next_q);

	// status to the sequencer
	assign stat.op        = op_q;
	assign stat.full      = (next_q == NXW'(MAX_NODES));
	assign stat.a_ok      = (a_wide < IW'(next_q)) && live_q[a_idx];
	assign stat.b_ok      = (b_wide < IW'(next_q)) && live_q[b_idx];
	assign stat.walk_last = walk_last;

	gs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	gs_row_ram #(
		.DEPTH (MAX_NODES),
		.WIDTH (MAX_NODES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// memory access and count delta per action
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = a_idx;
		ram_wdata   = ram_rdata;
		ram_re      = 1'b0;
		ram_raddr   = a_idx;
		cnt_sub     = 1'b0;
		cnt_amt     = 2'd0;
		res_load    = 1'b0;
		res_status  = ST_NOCHANGE;
		res_present = 1'b0;
		res_new     = '0;
		unique case (ctrl.act)
			ACT_ADD: begin
				ram_we     = 1'b1;
				ram_waddr  = fresh_idx;
				ram_wdata  = '0;
				res_load   = 1'b1;
				res_status = ST_DONE;
				res_new    = 6'(fresh_idx);
			end
			ACT_FULL: begin
				res_load   = 1'b1;
				res_status = ST_FULL;
			end
			ACT_ABSENT: begin
				res_load   = 1'b1;
				res_status = ST_ABSENT;
			end
			ACT_UNKNOWN: begin
				res_load   = 1'b1;
				res_status = ST_NOCHANGE;
			end
			ACT_EDGE_RD, ACT_DEL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = a_idx;
			end
			ACT_EDGE_EX: begin
				res_load = 1'b1;
				case (op_q)
					OP_ADD_EDGE: begin
						if (!edge_bit) begin
							ram_we     = 1'b1;
							ram_wdata  = ram_rdata | b_mask;
							cnt_amt    = 2'd1;
							res_status = ST_DONE;
						end
					end
					OP_DEL_EDGE: begin
						if (edge_bit) begin
							ram_we     = 1'b1;
							ram_wdata  = ram_rdata & ~b_mask;
							cnt_sub    = 1'b1;
							cnt_amt    = 2'd1;
							res_status = ST_DONE;
						end
					end
					default: begin
						res_status  = ST_DONE;
						res_present = edge_bit;
					end
				endcase
			end
			ACT_DEL_LOAD: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ACT_WALK: begin
				// clear column bit of row j; row a itself is wiped at its turn
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = j_is_a ? '0 : (ram_rdata & ~a_mask);
				ram_re    = !walk_last;
				ram_raddr = NW'(j_q + NW'(1));
				cnt_sub   = 1'b1;
				cnt_amt   = 2'(row_q[j_q]) + 2'(ram_rdata[a_idx] && !j_is_a);
				res_load  = walk_last;
				res_status = ST_DONE;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// shared add/subtract on the edge count
	assign cnt_next = cnt_sub ? (count_q - CW'(cnt_amt)) : (count_q + CW'(cnt_amt));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			next_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= res_load;
			count_q <= cnt_next;
			if (ctrl.act == ACT_ADD) begin
				live_q[fresh_idx] <= 1'b1;
				next_q            <= next_q + NXW'(1);
			end
			if (ctrl.act == ACT_DEL_RD) begin
				live_q[a_idx] <= 1'b0;
			end
		end
	end

	// item capture and walk registers
	always_ff @(posedge clk) begin
		if (ctrl.act == ACT_CAPTURE) begin
			op_q <= opcode;
			a_q  <= node_a;
			b_q  <= node_b;
		end
		if (ctrl.act == ACT_DEL_LOAD) begin
			row_q <= ram_rdata;
			j_q   <= '0;
		end else if (ctrl.act == ACT_WALK) begin
			j_q <= NW'(j_q + NW'(1));
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q    <= res_status;
			new_node_q  <= res_new;
			present_q   <= res_present;
			count_out_q <= 13'(cnt_next);
			used_q      <= (ctrl.act == ACT_ADD) ? 7'(next_q + NXW'(1)) : 7'(next_q);
		end
	end

	assign busy         = ctrl.busy;
	assign done         = done_q;
	assign status       = status_q;
	assign new_node     = new_node_q;
	assign edge_present = present_q;
	assign edge_count   = count_out_q;
	assign nodes_used   = used_q;

	// a result strobe is never followed directly by another
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("back-to-back result strobes");

	// an accepted item holds the block busy for the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");

	// index allocation never passes capacity
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= NXW'(MAX_NODES)) else $error("next index past capacity");

	// no node beyond the handed-out range is live
	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q >> next_q) == '0) else $error("live mark beyond next index");

	// edge count never exceeds the matrix size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES * MAX_NODES)) else $error("edge count overflow");

endmodule

// ===== tb/adjacency_matrix_graph_store_check.sv =====
// Checker for the adjacency-matrix graph store: watches the item and result channels,
// predicts every result from its own copy of the graph and compares field by field.
// Depends on gs_pkg for opcodes and status codes.
module adjacency_matrix_graph_store_check import gs_pkg::*; #(
	parameter int MAX_NODES = GS_MAX_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  opcode,
	input  logic [5:0]  node_a,
	input  logic [5:0]  node_b,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [5:0]  new_node,
	input  logic        edge_present,
	input  logic [12:0] edge_count,
	input  logic [6:0]  nodes_used,
	output int          mismatches,
	output int          replies_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t     status;
		logic [5:0]  new_node;
		logic        edge_present;
		logic [12:0] edge_count;
		logic [6:0]  nodes_used;
	} graph_reply_t;

	// shadow copy of the graph
	bit [63:0]    adj [64];
	bit [63:0]    live;
	bit [6:0]     next_idx;
	bit [12:0]    edge_total;
	graph_reply_t replies_due [$];
	graph_reply_t want;

	function automatic bit node_usable(input logic [5:0] idx);
		return (idx < next_idx) && (idx < MAX_NODES) && live[idx];
	endfunction

	// apply one item to the shadow graph and return the reply it must give
	function automatic graph_reply_t apply_graph_op(input logic [2:0] op,
			input logic [5:0] a, input logic [5:0] b);
		graph_reply_t r;
		r.status = ST_NOCHANGE;
		r.new_node = '0;
		r.edge_present = 1'b0;
		case (op) inside
			OP_ADD_NODE: begin
				if (next_idx >= MAX_NODES) begin
					r.status = ST_FULL;
				end else begin
					r.new_node = next_idx[5:0];
					live[next_idx[5:0]] = 1'b1;
					adj[next_idx[5:0]] = '0;
					next_idx++;
					r.status = ST_DONE;
				end
			end
			OP_DEL_NODE: begin
				if (!node_usable(a)) begin
					r.status = ST_ABSENT;
				end else begin
					live[a] = 1'b0;
					// row first, then column, so a self loop is counted once
					for (int j = 0; j < next_idx && j < MAX_NODES; j++) begin
						if (adj[a][j]) begin
							adj[a][j] = 1'b0;
							edge_total--;
						end
						if (adj[j][a]) begin
							adj[j][a] = 1'b0;
							edge_total--;
						end
					end
					r.status = ST_DONE;
				end
			end
			OP_ADD_EDGE, OP_DEL_EDGE, OP_QUERY_EDGE: begin
				if (!node_usable(a) || !node_usable(b)) begin
					r.status = ST_ABSENT;
				end else if (op == OP_QUERY_EDGE) begin
					r.edge_present = adj[a][b];
					r.status = ST_DONE;
				end else if (op == OP_ADD_EDGE) begin
					if (adj[a][b]) begin
						r.status = ST_NOCHANGE;
					end else begin
						adj[a][b] = 1'b1;
						edge_total++;
						r.status = ST_DONE;
					end
				end else begin
					if (!adj[a][b]) begin
						r.status = ST_NOCHANGE;
					end else begin
						adj[a][b] = 1'b0;
						edge_total--;
						r.status = ST_DONE;
					end
				end
			end
			default: r.status = ST_NOCHANGE;
		endcase
		r.edge_count = edge_total;
		r.nodes_used = next_idx;
		return r;
	endfunction

	// result check first (it belongs to an older item), then capture a new item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (adj[i]) adj[i] = '0;
			live = '0;
			next_idx = '0;
			edge_total = '0;
			replies_due.delete();
			mismatches = 0;
			replies_pending = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no item outstanding: status %0d count %0d",
							$realtime, status, edge_count);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status || new_node !== want.new_node ||
							edge_present !== want.edge_present ||
							edge_count !== want.edge_count ||
							nodes_used !== want.nodes_used) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: mismatch (exp/got) status %0d/%0d new_node %0d/%0d",
								$realtime, want.status, status, want.new_node, new_node);
							$display(" edge_present %0d/%0d edge_count %0d/%0d nodes_used %0d/%0d",
								want.edge_present, edge_present, want.edge_count, edge_count,
								want.nodes_used, nodes_used);
						end
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_graph_op(opcode, node_a, node_b));
			replies_pending = replies_due.size();
		end
	end

endmodule

// ===== tb/adjacency_matrix_graph_store_tb.sv =====
// Testbench top for adjacency_matrix_graph_store: clock, reset, directed and random items.
// Depends on gs_pkg, the block and adjacency_matrix_graph_store_check.
module adjacency_matrix_graph_store_tb import gs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [5:0]  node_a;
	logic [5:0]  node_b;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  new_node;
	logic        edge_present;
	logic [12:0] edge_count;
	logic [6:0]  nodes_used;
	int          mismatches;
	int          replies_pending;

	// stimulus bookkeeping: indices handed out so far, and idle mode
	int          issued;
	bit          no_idle;

	adjacency_matrix_graph_store uut (
		.clk, .arst_n, .start, .busy, .opcode, .node_a, .node_b,
		.done, .status, .new_node, .edge_present, .edge_count, .nodes_used
	);

	adjacency_matrix_graph_store_check u_check (
		.clk, .arst_n, .start, .busy, .opcode, .node_a, .node_b,
		.done, .status, .new_node, .edge_present, .edge_count, .nodes_used,
		.mismatches, .replies_pending
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// drive one item after a random gap and hold it until accepted
	task automatic send_item(input logic [2:0] op, input logic [5:0] a, input logic [5:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		node_a <= a;
		node_b <= b;
		if (op == OP_ADD_NODE && issued < GS_MAX_NODES)
			issued++;
		do @(posedge clk); while (busy);
	endtask

	// recent nodes about half the time so edges pile up, else any issued index, sometimes any index at all
	function automatic logic [5:0] pick_node();
		int r;
		int lo;
		r = $urandom_range(0, 99);
		lo = (issued > 8) ? issued - 8 : 0;
		if (issued == 0 || r < 8)
			return 6'($urandom_range(0, 63));
		else if (r < 55)
			return 6'($urandom_range(lo, issued - 1));
		else
			return 6'($urandom_range(0, issued - 1));
	endfunction

	initial begin
		int r;
		logic [2:0] op;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = '0;
		node_a = '0;
		node_b = '0;
		issued = 0;
		no_idle = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty store: everything is absent, unknown codes change nothing
		send_item(OP_ADD_EDGE, 6'd0, 6'd0);
		send_item(OP_QUERY_EDGE, 6'd0, 6'd0);
		send_item(OP_DEL_NODE, 6'd0, 6'd0);
		send_item(3'd7, 6'd63, 6'd63);
		repeat (4) send_item(OP_ADD_NODE, 6'd0, 6'd0);
		// edge set, repeat, query both directions, self loop
		send_item(OP_ADD_EDGE, 6'd0, 6'd1);
		send_item(OP_ADD_EDGE, 6'd0, 6'd1);
		send_item(OP_QUERY_EDGE, 6'd0, 6'd1);
		send_item(OP_QUERY_EDGE, 6'd1, 6'd0);
		send_item(OP_ADD_EDGE, 6'd2, 6'd2);
		send_item(OP_ADD_EDGE, 6'd1, 6'd2);
		send_item(OP_ADD_EDGE, 6'd2, 6'd0);
		// index not yet handed out
		send_item(OP_ADD_EDGE, 6'd0, 6'd4);
		send_item(OP_DEL_EDGE, 6'd0, 6'd1);
		send_item(OP_DEL_EDGE, 6'd0, 6'd1);
		// delete a node with a self loop and edges both ways
		send_item(OP_DEL_NODE, 6'd2, 6'd0);
		send_item(OP_QUERY_EDGE, 6'd2, 6'd2);
		send_item(OP_DEL_NODE, 6'd2, 6'd0);
		// freed index is not reused
		send_item(OP_ADD_NODE, 6'd0, 6'd0);
		send_item(3'd5, 6'd0, 6'd63);
		send_item(3'd6, 6'd42, 6'd21);
		send_item(OP_QUERY_EDGE, 6'd63, 6'd0);

		// random traffic; store fills up part way through
		for (int n = 0; n < 1830; n++) begin
			if ($urandom_range(0, 99) == 0)
				no_idle = ~no_idle;
			r = $urandom_range(0, 99);
			if (r < 5)
				op = OP_ADD_NODE;
			else if (r < 8)
				op = OP_DEL_NODE;
			else if (r < 40)
				op = OP_ADD_EDGE;
			else if (r < 60)
				op = OP_DEL_EDGE;
			else if (r < 93)
				op = OP_QUERY_EDGE;
			else
				op = 3'($urandom_range(5, 7));
			send_item(op, pick_node(), pick_node());
		end

		@(negedge clk) start <= 1'b0;
		wait (replies_pending == 0);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#12ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gs_pkg.sv
hdl/gs_row_ram.sv
hdl/gs_seq.sv
hdl/adjacency_matrix_graph_store.sv
tb/adjacency_matrix_graph_store_check.sv
tb/adjacency_matrix_graph_store_tb.sv
